[rtl/assert_macros.svh]
// Assertion macros for the cache RTL, used by ttc_back.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TTC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
`define TTC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `TTC_ASSERT(lbl, clk, rstn, !(cond))
`else
`define TTC_ASSERT(lbl, clk, rstn, prop)
`define TTC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/ttc_pkg.sv]
// Types, constants and codes for the transposition table cache.
// Used by every module of the block but ttc_ram; depends on nothing.
package ttc_pkg;

  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int unsigned PLY_LIMIT   = 128;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] DEPTH_CAP = 7'd127;
  localparam logic [6:0] PLY_MAX   = 7'(PLY_LIMIT - 1);

  localparam logic [14:0] MATE_THR_RESET = 15'd30000;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_GEN = 1'd1;

  typedef enum logic {
    FUNC_PROBE = 1'b0,
    FUNC_STORE = 1'b1
  } ttc_func_e;

  // one item as it waits between front and back
  typedef struct packed {
    ttc_func_e   func;
    logic [63:0] hash;
    logic [7:0]  depth_in;
    logic [6:0]  depth_sat;
    logic [15:0] score;     // already adjusted for mate on a store
    logic [1:0]  bound;
    logic [31:0] move;
    logic [6:0]  ply;
  } ttc_entry_t;

  // one table slot as held in the RAM
  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] move;
    logic [15:0] score;
    logic [6:0]  depth;
    logic [1:0]  bound;
    logic [7:0]  gen;
  } ttc_slot_t;

  localparam int unsigned SLOT_W = $bits(ttc_slot_t);

endpackage

[rtl/ttc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ttc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ttc_front.sv]
// Front end: accepts items, saturates ply and depth, adjusts mate scores
// for stores and queues the entries for the back end. Depends on ttc_pkg.
module ttc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [63:0]         position_hash_i,
  input  logic [7:0]          search_depth_i,
  input  logic signed [15:0]  score_in_i,
  input  logic [1:0]          bound_kind_i,
  input  logic [31:0]         move_in_i,
  input  logic [6:0]          ply_from_root_i,
  input  logic [14:0]         mate_thr_i,
  input  logic                clear_done_i,
  output logic                q_valid_o,
  output ttc_pkg::ttc_entry_t q_entry_o,
  input  logic                q_pop_i
);
  import ttc_pkg::*;

  ttc_entry_t        entry;
  ttc_entry_t        buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic [6:0]        ply;
  logic signed [17:0] s_ext, thr_pos, thr_neg, ply_ext, s_adj;

  always_comb begin
    ply     = (ply_from_root_i > PLY_MAX) ? PLY_MAX : ply_from_root_i;
    s_ext   = 18'(score_in_i);
    thr_pos = $signed({3'b000, mate_thr_i});
    thr_neg = -thr_pos;
    ply_ext = $signed({11'd0, ply});
    // push mate scores away from zero so they are relative to this node
    if (s_ext >= thr_pos) begin
      s_adj = s_ext + ply_ext;
    end else if (s_ext <= thr_neg) begin
      s_adj = s_ext - ply_ext;
    end else begin
      s_adj = s_ext;
    end

    entry.func      = ttc_func_e'(func_i);
    entry.hash      = position_hash_i;
    entry.depth_in  = search_depth_i;
    entry.depth_sat = (search_depth_i > {1'b0, DEPTH_CAP}) ? DEPTH_CAP
                                                            : search_depth_i[6:0];
    entry.score     = s_adj[15:0];
    entry.bound     = bound_kind_i;
    entry.move      = move_in_i;
    entry.ply       = ply;
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && clear_done_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= entry;
    end
  end

endmodule

[rtl/ttc_back.sv]
// Back end: clears the table after reset, then per item reads the slot,
// decides hit or replacement, writes the slot on a store and holds the
// result beat. Depends on ttc_pkg, ttc_ram and assert_macros.svh.
`include "assert_macros.svh"

module ttc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [14:0]         mate_thr_i,
  input  logic [7:0]          search_gen_i,
  input  logic                q_valid_i,
  input  ttc_pkg::ttc_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                clear_done_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [31:0]         move_out_o,
  output logic signed [16:0]  score_out_o,
  output logic [6:0]          depth_out_o,
  output logic [1:0]          bound_out_o,
  output logic                written_o
);
  import ttc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e               state_q;
  logic [SLOT_BITS-1:0] clr_cnt_q;
  ttc_entry_t           cur_q;

  logic               out_valid_q, out_hit_q, out_written_q;
  logic [31:0]        out_move_q;
  logic signed [16:0] out_score_q;
  logic [6:0]         out_depth_q;
  logic [1:0]         out_bound_q;

  logic                 ram_we, ram_re;
  logic [SLOT_BITS-1:0] ram_waddr;
  logic [SLOT_W-1:0]    ram_wdata, ram_rdata;

  ttc_slot_t          rd_slot, wr_slot;
  logic               key_match, skip, is_store, can_emit, hit, emit;
  logic signed [16:0] s_ext, thr_pos, thr_neg, ply_ext, s_adj;

  always_comb begin
    rd_slot   = ttc_slot_t'(ram_rdata);
    is_store  = (cur_q.func == FUNC_STORE);
    key_match = rd_slot.valid && (rd_slot.key == cur_q.hash);
    skip      = key_match && (rd_slot.gen == search_gen_i) &&
                ({1'b0, rd_slot.depth} > cur_q.depth_in);
    hit       = key_match && !is_store;
    can_emit  = !out_valid_q || out_ready_i;
    emit      = (state_q == ST_LOOK) && can_emit;

    // pull mate scores back toward zero so they are relative to the root
    s_ext   = 17'($signed(rd_slot.score));
    thr_pos = $signed({2'b00, mate_thr_i});
    thr_neg = -thr_pos;
    ply_ext = $signed({10'd0, cur_q.ply});
    if (s_ext >= thr_pos) begin
      s_adj = s_ext - ply_ext;
    end else if (s_ext <= thr_neg) begin
      s_adj = s_ext + ply_ext;
    end else begin
      s_adj = s_ext;
    end

    wr_slot.valid = 1'b1;
    wr_slot.key   = cur_q.hash;
    wr_slot.move  = cur_q.move;
    wr_slot.score = cur_q.score;
    wr_slot.depth = cur_q.depth_sat;
    wr_slot.bound = cur_q.bound;
    wr_slot.gen   = search_gen_i;

    ram_re  = (state_q == ST_IDLE) && q_valid_i;
    q_pop_o = ram_re;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == ST_LOOK) && can_emit && is_store && !skip;
      ram_waddr = cur_q.hash[SLOT_BITS-1:0];
      ram_wdata = wr_slot;
    end
  end

  ttc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_entry_i.hash[SLOT_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      cur_q         <= '0;
      out_valid_q   <= 1'b0;
      out_hit_q     <= 1'b0;
      out_written_q <= 1'b0;
      out_move_q    <= '0;
      out_score_q   <= '0;
      out_depth_q   <= '0;
      out_bound_q   <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            cur_q   <= q_entry_i;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          // hold here while the previous beat is still waiting
          if (can_emit) begin
            out_hit_q     <= hit;
            out_written_q <= is_store && !skip;
            out_move_q    <= hit ? rd_slot.move : '0;
            out_score_q   <= hit ? s_adj : '0;
            out_depth_q   <= hit ? rd_slot.depth : '0;
            out_bound_q   <= hit ? rd_slot.bound : '0;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign clear_done_o = (state_q != ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign move_out_o   = out_move_q;
  assign score_out_o  = out_score_q;
  assign depth_out_o  = out_depth_q;
  assign bound_out_o  = out_bound_q;
  assign written_o    = out_written_q;

  `TTC_ASSERT(a_pop_only_idle, clk_i, rst_ni, q_pop_o |-> (state_q == ST_IDLE))
  `TTC_ASSERT(a_look_emits, clk_i, rst_ni, emit |=> (out_valid_q && state_q == ST_IDLE))
  `TTC_ASSERT_NEVER(a_hit_and_written, clk_i, rst_ni, out_valid_q && out_hit_q && out_written_q)
  `TTC_ASSERT_NEVER(a_slot_write_no_beat, clk_i, rst_ni, ram_we && state_q == ST_IDLE)

endmodule

[rtl/transposition_table_cache_top.sv]
// Top level of the transposition table cache: configuration registers,
// front end with its queue, and back end with the slot RAM.
// Depends on ttc_pkg, ttc_front and ttc_back.
// Direct-mapped cache of 4096 slots keyed by the low 12 bits of a 64-bit
// position hash. After reset the back end sweeps the slot RAM clearing the
// valid marks; in_ready_o stays low during that sweep, while configuration
// writes are taken at any time. Afterwards ST_IDLE reads each item's slot from
// the RAM (registered read) and ST_LOOK compares, writes the slot on a store
// and loads the result beat, holding while an earlier beat waits; the next item
// is taken only after ST_LOOK. A two-entry queue between front and back lets
// the input side keep accepting while a result waits. The user must write
// configuration only while the block holds no item in flight; the block itself
// does not enforce this.
module transposition_table_cache_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ttc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [63:0]                      position_hash_i,
  input  logic [7:0]                       search_depth_i,
  input  logic signed [15:0]               score_in_i,
  input  logic [1:0]                       bound_kind_i,
  input  logic [31:0]                      move_in_i,
  input  logic [6:0]                       ply_from_root_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [31:0]                      move_out_o,
  output logic signed [16:0]               score_out_o,
  output logic [6:0]                       depth_out_o,
  output logic [1:0]                       bound_out_o,
  output logic                             written_o
);
  import ttc_pkg::*;

  logic [14:0] mate_thr_q;
  logic [7:0]  search_gen_q;
  logic        q_valid, q_pop, clear_done;
  ttc_entry_t  q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_thr_q   <= MATE_THR_RESET;
      search_gen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MATE_THR:   mate_thr_q   <= cfg_wdata_i[14:0];
        CFG_SEARCH_GEN: search_gen_q <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  ttc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .position_hash_i (position_hash_i),
    .search_depth_i  (search_depth_i),
    .score_in_i      (score_in_i),
    .bound_kind_i    (bound_kind_i),
    .move_in_i       (move_in_i),
    .ply_from_root_i (ply_from_root_i),
    .mate_thr_i      (mate_thr_q),
    .clear_done_i    (clear_done),
    .q_valid_o       (q_valid),
    .q_entry_o       (q_entry),
    .q_pop_i         (q_pop)
  );

  ttc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mate_thr_i   (mate_thr_q),
    .search_gen_i (search_gen_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .clear_done_o (clear_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .move_out_o   (move_out_o),
    .score_out_o  (score_out_o),
    .depth_out_o  (depth_out_o),
    .bound_out_o  (bound_out_o),
    .written_o    (written_o)
  );

endmodule

[sim/tb_transposition_table_cache_top.sv]
// Self-checking testbench for transposition_table_cache_top: directed and random
// probe/store traffic with random stalls, checked against an in-bench cache model.
// Depends on ttc_pkg and the cache RTL.
module tb_transposition_table_cache_top;
  import ttc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned GAP_MAX     = 13;
  localparam int unsigned POOL_SIZE   = 24;

  typedef struct packed {
    ttc_func_e   func;
    logic [63:0] hash;
    logic [7:0]  depth;
    logic [15:0] score;
    logic [1:0]  bound;
    logic [31:0] move;
    logic [6:0]  ply;
  } tt_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] move;
    logic [16:0] score;
    logic [6:0]  depth;
    logic [1:0]  bound;
    logic        written;
  } tt_resp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  func_i;
  logic [63:0]           position_hash_i;
  logic [7:0]            search_depth_i;
  logic signed [15:0]    score_in_i;
  logic [1:0]            bound_kind_i;
  logic [31:0]           move_in_i;
  logic [6:0]            ply_from_root_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  hit_o;
  logic [31:0]           move_out_o;
  logic signed [16:0]    score_out_o;
  logic [6:0]            depth_out_o;
  logic [1:0]            bound_out_o;
  logic                  written_o;

  transposition_table_cache_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .position_hash_i (position_hash_i),
    .search_depth_i  (search_depth_i),
    .score_in_i      (score_in_i),
    .bound_kind_i    (bound_kind_i),
    .move_in_i       (move_in_i),
    .ply_from_root_i (ply_from_root_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .move_out_o      (move_out_o),
    .score_out_o     (score_out_o),
    .depth_out_o     (depth_out_o),
    .bound_out_o     (bound_out_o),
    .written_o       (written_o)
  );

  // shadow copy of the table and its registers
  logic [63:0] tt_key   [TABLE_SLOTS];
  logic [31:0] tt_move  [TABLE_SLOTS];
  logic [15:0] tt_score [TABLE_SLOTS];
  logic [6:0]  tt_depth [TABLE_SLOTS];
  logic [1:0]  tt_bound [TABLE_SLOTS];
  logic [7:0]  tt_gen   [TABLE_SLOTS];
  bit          tt_valid [TABLE_SLOTS];
  logic [14:0] mate_thr   = MATE_THR_RESET;
  logic [7:0]  search_gen = 8'd0;

  tt_resp_t    pending_resp[$];
  logic [63:0] hash_pool[POOL_SIZE];
  int          mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  bit          rx_hold_req  = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Probe or store against the shadow table; returns the result beat it causes.
  function automatic tt_resp_t cache_access(tt_req_t r);
    tt_resp_t             rsp;
    logic [SLOT_BITS-1:0] idx;
    logic [6:0]           ply;
    int                   thr;
    int                   p;
    int                   s;
    rsp = '0;
    idx = r.hash[SLOT_BITS-1:0];
    thr = int'(mate_thr);
    ply = (r.ply > PLY_MAX) ? PLY_MAX : r.ply;
    p   = int'(ply);
    if (r.func == FUNC_PROBE) begin
      if (tt_valid[idx] && tt_key[idx] == r.hash) begin
        s = int'($signed(tt_score[idx]));
        if (s >= thr)
          s -= p;
        else if (s <= -thr)
          s += p;
        rsp.hit   = 1'b1;
        rsp.move  = tt_move[idx];
        rsp.score = s[16:0];
        rsp.depth = tt_depth[idx];
        rsp.bound = tt_bound[idx];
      end
      return rsp;
    end
    // keep a deeper entry of this search for the same position
    if (tt_valid[idx] && tt_key[idx] == r.hash && tt_gen[idx] == search_gen &&
        {1'b0, tt_depth[idx]} > r.depth)
      return rsp;
    s = int'($signed(r.score));
    if (s >= thr)
      s += p;
    else if (s <= -thr)
      s -= p;
    tt_key[idx]   = r.hash;
    tt_move[idx]  = r.move;
    tt_score[idx] = s[15:0];
    tt_depth[idx] = (r.depth > {1'b0, DEPTH_CAP}) ? DEPTH_CAP : r.depth[6:0];
    tt_bound[idx] = r.bound;
    tt_gen[idx]   = search_gen;
    tt_valid[idx] = 1'b1;
    rsp.written   = 1'b1;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  // Predict on every input beat, check every result beat against the oldest prediction.
  always @(posedge clk_i) begin
    tt_req_t  req;
    tt_resp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        req.func  = ttc_func_e'(func_i);
        req.hash  = position_hash_i;
        req.depth = search_depth_i;
        req.score = score_in_i;
        req.bound = bound_kind_i;
        req.move  = move_in_i;
        req.ply   = ply_from_root_i;
        pending_resp.insert(pending_resp.size(), cache_access(req));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_resp.size() == 0) begin
          report_mismatch("result beat with nothing pending", 64'(hit_o), 64'd0);
        end else begin
          want = pending_resp.pop_front();
          if (hit_o !== want.hit)
            report_mismatch("hit", 64'(hit_o), 64'(want.hit));
          if (move_out_o !== want.move)
            report_mismatch("move", 64'(move_out_o), 64'(want.move));
          if (score_out_o !== want.score)
            report_mismatch("score", 64'(score_out_o), 64'(want.score));
          if (depth_out_o !== want.depth)
            report_mismatch("depth", 64'(depth_out_o), 64'(want.depth));
          if (bound_out_o !== want.bound)
            report_mismatch("bound", 64'(bound_out_o), 64'(want.bound));
          if (written_o !== want.written)
            report_mismatch("written", 64'(written_o), 64'(want.written));
        end
      end
    end
  end

  // Result side: stall a random number of cycles per beat while rx_idle_on is set, or a long stretch on request.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
      if (rx_hold_req) begin
        stall       = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_beat(input tt_req_t r);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= r.func;
    position_hash_i <= r.hash;
    search_depth_i  <= r.depth;
    score_in_i      <= r.score;
    bound_kind_i    <= r.bound;
    move_in_i       <= r.move;
    ply_from_root_i <= r.ply;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_MATE_THR)
      mate_thr = data;
    else
      search_gen = data[7:0];
  endtask

  function automatic tt_req_t make_req(ttc_func_e f, logic [63:0] h, logic [7:0] d,
                                       logic [15:0] s, logic [1:0] b, logic [31:0] m,
                                       logic [6:0] p);
    tt_req_t r;
    r.func  = f;
    r.hash  = h;
    r.depth = d;
    r.score = s;
    r.bound = b;
    r.move  = m;
    r.ply   = p;
    return r;
  endfunction

  // Scores cluster around the mate threshold and the 16-bit extremes.
  function automatic logic [15:0] rand_score();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v = int'(mate_thr) - 100 + int'($urandom_range(0, 200));
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1)) v = -v;
        return v[15:0];
      end
      3:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_depth();
    if ($urandom_range(0, 4) == 0)
      return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 40));
  endfunction

  function automatic logic [63:0] rand_hash();
    if ($urandom_range(0, 6) == 0)
      return {$urandom, $urandom};
    return hash_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic tt_req_t rand_req(ttc_func_e f, logic [63:0] h);
    return make_req(f, h, rand_depth(), rand_score(),
                    ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                    $urandom, 7'($urandom_range(0, 127)));
  endfunction

  // --------------------------------------------------------------------------
  task automatic test_basic_hit_miss();
    send_beat(make_req(FUNC_PROBE, 64'h0123_4567_89AB_CDEF, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    send_beat(make_req(FUNC_STORE, 64'h0123_4567_89AB_CDEF, 8'd10, 16'd100, 2'd0,
                       32'hFFFF_FFFF, 7'd5));
    send_beat(make_req(FUNC_PROBE, 64'h0123_4567_89AB_CDEF, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    // extreme keys; same slot, different key must miss
    send_beat(make_req(FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h8000, 2'd2,
                       32'd0, 7'd127));
    send_beat(make_req(FUNC_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'd0, 2'd0, 32'd0, 7'd127));
    send_beat(make_req(FUNC_STORE, 64'h0, 8'd255, 16'h7FFF, 2'd1, 32'hA5A5_5A5A, 7'd0));
    send_beat(make_req(FUNC_PROBE, 64'h0, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    send_beat(make_req(FUNC_PROBE, 64'h8000_0000_0000_0000, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    drain_results();
  endtask

  task automatic test_mate_scores();
    // mate on both sides, including the 16-bit wrap at the top ply
    send_beat(make_req(FUNC_STORE, 64'h1111_0000_0000_0101, 8'd4, 16'd30000, 2'd0,
                       32'h1, 7'd127));
    send_beat(make_req(FUNC_PROBE, 64'h1111_0000_0000_0101, 8'd0, 16'd0, 2'd0, 32'd0, 7'd3));
    send_beat(make_req(FUNC_STORE, 64'h2222_0000_0000_0102, 8'd4, 16'h8000, 2'd0,
                       32'h2, 7'd127));
    send_beat(make_req(FUNC_PROBE, 64'h2222_0000_0000_0102, 8'd0, 16'd0, 2'd0, 32'd0, 7'd127));
    drain_results();
    cfg_write(CFG_MATE_THR, 15'd0);
    send_beat(make_req(FUNC_STORE, 64'h3333_0000_0000_0103, 8'd4, 16'd0, 2'd0, 32'h3, 7'd10));
    send_beat(make_req(FUNC_STORE, 64'h4444_0000_0000_0104, 8'd4, 16'hFFFF, 2'd0, 32'h4, 7'd10));
    send_beat(make_req(FUNC_PROBE, 64'h3333_0000_0000_0103, 8'd0, 16'd0, 2'd0, 32'd0, 7'd1));
    send_beat(make_req(FUNC_PROBE, 64'h4444_0000_0000_0104, 8'd0, 16'd0, 2'd0, 32'd0, 7'd1));
    drain_results();
    cfg_write(CFG_MATE_THR, 15'h7FFF);
    send_beat(make_req(FUNC_STORE, 64'h5555_0000_0000_0105, 8'd4, 16'h8001, 2'd0, 32'h5, 7'd9));
    send_beat(make_req(FUNC_PROBE, 64'h5555_0000_0000_0105, 8'd0, 16'd0, 2'd0, 32'd0, 7'd2));
    drain_results();
    cfg_write(CFG_MATE_THR, MATE_THR_RESET);
  endtask

  task automatic test_replacement();
    logic [63:0] h;
    h = 64'h6666_7777_8888_0ABC;
    cfg_write(CFG_SEARCH_GEN, 15'd0);
    send_beat(make_req(FUNC_STORE, h, 8'd255, 16'd50, 2'd3, 32'h10, 7'd0));
    send_beat(make_req(FUNC_STORE, h, 8'd127, 16'd60, 2'd1, 32'h11, 7'd0));
    send_beat(make_req(FUNC_STORE, h, 8'd5, 16'd70, 2'd2, 32'h12, 7'd0));
    send_beat(make_req(FUNC_PROBE, h, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    drain_results();
    // a newer search overwrites a deeper entry
    cfg_write(CFG_SEARCH_GEN, 15'd255);
    send_beat(make_req(FUNC_STORE, h, 8'd5, 16'd80, 2'd3, 32'h13, 7'd0));
    send_beat(make_req(FUNC_PROBE, h, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    send_beat(make_req(FUNC_STORE, h ^ 64'h1_0000_0000, 8'd0, 16'd0, 2'd0, 32'h14, 7'd0));
    send_beat(make_req(FUNC_PROBE, h, 8'd0, 16'd0, 2'd0, 32'd0, 7'd0));
    drain_results();
  endtask

  task automatic test_backpressure();
    logic [63:0] h;
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      h = rand_hash();
      send_beat(rand_req(FUNC_STORE, h));
      send_beat(rand_req(FUNC_PROBE, h));
    end
    tx_idle_on = 1'b1;
    drain_results();
  endtask

  task automatic run_random_phase(int unsigned n_items, logic [14:0] thr, logic [7:0] gen);
    logic [63:0] h;
    int unsigned sent;
    cfg_write(CFG_MATE_THR, thr);
    cfg_write(CFG_SEARCH_GEN, 15'(gen));
    sent = 0;
    while (sent < n_items) begin
      h = rand_hash();
      if ($urandom_range(0, 9) < 7) begin
        // store, sometimes restore, then look it up again
        send_beat(rand_req(FUNC_STORE, h));
        sent++;
        if ($urandom_range(0, 3) == 0) begin
          send_beat(rand_req(FUNC_STORE, h));
          sent++;
        end
        send_beat(rand_req(FUNC_PROBE, h));
        sent++;
      end else begin
        send_beat(rand_req(ttc_func_e'($urandom_range(0, 1)), h));
        sent++;
      end
      if (sent == n_items / 2)
        drain_results();
    end
    drain_results();
  endtask

  task automatic test_random();
    logic [SLOT_BITS-1:0] slot;
    for (int i = 0; i < POOL_SIZE; i += 2) begin
      slot             = SLOT_BITS'($urandom_range(0, TABLE_SLOTS - 1));
      hash_pool[i]     = {$urandom, $urandom};
      hash_pool[i + 1] = {$urandom, $urandom};
      hash_pool[i][SLOT_BITS-1:0]     = slot;
      hash_pool[i + 1][SLOT_BITS-1:0] = slot;
    end
    run_random_phase(120, MATE_THR_RESET, 8'd0);
    run_random_phase(100, 15'($urandom_range(1, 32767)), 8'($urandom_range(1, 254)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random_phase(80, 15'h7FFF, 8'd255);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random_phase(100, 15'd1, 8'd0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MATE_THR;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    func_i          = FUNC_PROBE;
    position_hash_i = '0;
    search_depth_i  = '0;
    score_in_i      = '0;
    bound_kind_i    = '0;
    move_in_i       = '0;
    ply_from_root_i = '0;
    for (int i = 0; i < POOL_SIZE; i++)
      hash_pool[i] = {$urandom, $urandom};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_hit_miss();
    test_mate_scores();
    test_replacement();
    test_backpressure();
    test_random();

    drain_results();
    if (pending_resp.size() != 0)
      report_mismatch("results still pending", 64'(pending_resp.size()), 64'd0);
    if (mismatch_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
